/* rtl/dqs_pkg.sv */
// Shared types and codes for the deque-with-search block.
`default_nettype none

package dqs_pkg;

    // Input action codes
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_SEARCH     = 3'd4;
    localparam logic [2:0] ACT_DUMP_FWD   = 3'd5;
    localparam logic [2:0] ACT_DUMP_REV   = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = 1;
    localparam int CMDQ_CNT_W = 2;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_SEARCH,
        OP_DUMP_FWD,
        OP_DUMP_REV
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_POP,
        B_SCAN,
        B_DUMP
    } back_state_t;

endpackage

`default_nettype wire

/* rtl/dqs_front.sv */
// Front end: takes items and turns action codes into queued commands.
`default_nettype none

module dqs_front
    import dqs_pkg::*;
(
    input  wire logic               start,
    input  wire logic [2:0]         action,
    input  wire logic signed [31:0] value,
    input  wire logic               q_full,
    output      logic               push,
    output      cmd_t               cmd
);

    logic known;

    always_comb
    begin
        known  = 1'b1;
        cmd.op = OP_PUSH_FRONT;
        unique case (action)
            ACT_PUSH_FRONT: cmd.op = OP_PUSH_FRONT;
            ACT_PUSH_BACK:  cmd.op = OP_PUSH_BACK;
            ACT_POP_FRONT:  cmd.op = OP_POP_FRONT;
            ACT_POP_BACK:   cmd.op = OP_POP_BACK;
            ACT_SEARCH:     cmd.op = OP_SEARCH;
            ACT_DUMP_FWD:   cmd.op = OP_DUMP_FWD;
            ACT_DUMP_REV:   cmd.op = OP_DUMP_REV;
            default:        known  = 1'b0;  // spare code: accepted, dropped
        endcase
        cmd.value = value;
        push      = start && !q_full && known;
    end

endmodule

`default_nettype wire

/* rtl/dqs_cmdq.sv */
// Two-entry command queue between front end and back end.
`default_nettype none

module dqs_cmdq
    import dqs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t cmd_in,
    input  wire logic pop,
    output      cmd_t cmd_out,
    output      logic cmd_valid,
    output      logic full
);

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + CMDQ_CNT_W'(push) - CMDQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign cmd_out   = entry_reg[rd_ptr_reg];
    assign cmd_valid = (fill_reg != '0);
    assign full      = (fill_reg == CMDQ_CNT_W'(CMDQ_DEPTH));

endmodule

`default_nettype wire

/* rtl/dqs_back.sv */
// Back end: ring store, pointers and the sequencer that runs each command.
`default_nettype none

module dqs_back
    import dqs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire cmd_t               cmd,
    output      logic               cmd_pop,
    output      logic               done,
    output      logic [1:0]         status,
    output      logic [CNT_W-1:0]   position,
    output      logic signed [31:0] item,
    output      logic               last
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               wr_en;

    back_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               fwd_reg, fwd_next;
    logic signed [31:0] key_reg, key_next;

    logic               done_reg, done_next;
    logic [1:0]         status_reg, status_next;
    logic [CNT_W-1:0]   position_reg, position_next;
    logic signed [31:0] item_reg, item_next;
    logic               last_reg, last_next;

    logic [CNT_W-1:0]   idx_inc;

    // ring slot at a given offset from the front
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign idx_inc = idx_reg + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        fwd_next      = fwd_reg;
        key_next      = key_reg;
        done_next     = 1'b0;
        status_next   = ST_OK;
        position_next = '0;
        item_next     = '0;
        last_next     = 1'b1;
        wr_en         = 1'b0;
        wr_addr       = slot(front_reg, count_reg);
        rd_addr       = front_reg;
        cmd_pop       = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (cmd.op == OP_PUSH_FRONT)
                                begin
                                    front_next = (front_reg == '0) ? IDX_W'(DEPTH - 1)
                                                                   : front_reg - 1'b1;
                                    wr_addr    = front_next;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                state_next = B_POP;
                                if (cmd.op == OP_POP_FRONT)
                                begin
                                    rd_addr    = front_reg;
                                    front_next = slot(front_reg, CNT_W'(1));
                                end
                                else
                                begin
                                    rd_addr = slot(front_reg, count_reg - 1'b1);
                                end
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                rd_addr    = front_reg;
                                idx_next   = '0;
                                key_next   = cmd.value;
                                state_next = B_SCAN;
                            end
                        end
                        OP_DUMP_FWD, OP_DUMP_REV:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                fwd_next   = (cmd.op == OP_DUMP_FWD);
                                idx_next   = '0;
                                rd_addr    = (cmd.op == OP_DUMP_FWD)
                                           ? front_reg
                                           : slot(front_reg, count_reg - 1'b1);
                                state_next = B_DUMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_POP:
            begin
                done_next  = 1'b1;
                item_next  = rd_data_reg;
                state_next = B_IDLE;
            end
            B_SCAN:
            begin
                // rd_data_reg holds the entry at offset idx_reg
                rd_addr = slot(front_reg, idx_inc);
                if (rd_data_reg == key_reg)
                begin
                    done_next     = 1'b1;
                    position_next = idx_inc;
                    state_next    = B_IDLE;
                end
                else if (idx_inc == count_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOT_FOUND;
                    state_next  = B_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            B_DUMP:
            begin
                done_next = 1'b1;
                item_next = rd_data_reg;
                last_next = (idx_inc == count_reg);
                rd_addr   = fwd_reg ? slot(front_reg, idx_inc)
                                    : slot(front_reg, count_reg - idx_reg - CNT_W'(2));
                if (idx_inc == count_reg)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            fwd_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            fwd_reg   <= fwd_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        status_reg   <= status_next;
        position_reg <= position_next;
        item_reg     <= item_next;
        last_reg     <= last_next;
    end

    // ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign position = position_reg;
    assign item     = item_reg;
    assign last     = last_reg;

endmodule

`default_nettype wire

/* rtl/deque_with_search_unit.sv */
// Top level of the bounded deque with search and dump.
`default_nettype none

// Bounded double-ended queue of signed 32-bit values held in a DEPTH-word
// ring store, with search and dump.
//
// Command channel: an item (action, value) is taken at a rising edge where
// start is high and busy is low. Spare action code 7 is taken and dropped.
// Result channel: each result sits on status/position/item/last for one
// cycle, flagged by done. The receiver cannot stall; every result must be
// taken on the cycle it appears. last marks the final result of an item.
//
// Items pass through a two-entry command queue; busy is high while it is
// full. The back-end sequencer then runs one command at a time:
//   push        written to the ring store from the idle state
//   pop         registered read of the ring store, then the pop state
//   search      walks entries from the front until the first match
//   dump        walks every entry, one result per cycle, back to back
// An item's result is registered; pops, searches and dumps on a non-empty deque
// add a registered read of the ring store before it. Throughput is set by the
// single read port of the ring store, which search and dump walk one entry a cycle.
// Reset clears pointers, count and queue; the store keeps stale data, never read.

module deque_with_search_unit
    import dqs_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output      logic                         busy,
    input  wire logic [2:0]                   action,
    input  wire logic signed [31:0]           value,
    output      logic                         done,
    output      logic [1:0]                   status,
    output      logic [$clog2(DEPTH + 1)-1:0] position,
    output      logic signed [31:0]           item,
    output      logic                         last
);

    localparam int POS_W = $clog2(DEPTH + 1);

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic front_push;
    logic q_full;
    logic q_valid;
    logic back_pop;

    // classify incoming items
    dqs_front u_front (
        .start  (start),
        .action (action),
        .value  (value),
        .q_full (q_full),
        .push   (front_push),
        .cmd    (front_cmd)
    );

    // decouples accept from execution
    dqs_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .cmd_in    (front_cmd),
        .pop       (back_pop),
        .cmd_out   (back_cmd),
        .cmd_valid (q_valid),
        .full      (q_full)
    );

    // store, pointers and sequencer
    dqs_back #(
        .DEPTH (DEPTH),
        .CNT_W (POS_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (back_cmd),
        .cmd_pop   (back_pop),
        .done      (done),
        .status    (status),
        .position  (position),
        .item      (item),
        .last      (last)
    );

    assign busy = q_full;

`ifndef SYNTH
    // a match position is only reported with an ok status
    a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && position != '0) |-> (status == ST_OK && item == '0))
        else $error("position set on non-ok result");

    // error results always end their item
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> last)
        else $error("error result without last");

    // dump results come back to back until last
    a_dump_run: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |=> done)
        else $error("gap inside a dump");

    // queue only fills up after an item was taken
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an accepted item");
`endif

endmodule

`default_nettype wire
